// ===== sv/idp_pkg.sv =====
// ----------------------------------------------------------------------------
// Image datagram packetizer package
// Shared types and constants: item modes, result kinds, chunk size and the
// reciprocal used to turn a microsecond age into milliseconds.
// ----------------------------------------------------------------------------
package idp_pkg;

	// Payload bytes per datagram; must stay within 1..2047.
	localparam int unsigned CHUNK_SIZE = 1400;

	// Age in microseconds at and above which the millisecond age saturates.
	localparam logic [47:0] AGE_SAT_US = 48'd65536000;

	// ceil(2^36 / 1000); exact floor division for every value below 2^26.
	localparam logic [26:0] AGE_RECIP = 27'd68719477;
	localparam int unsigned AGE_SHIFT = 36;

	typedef enum logic [1:0] {
		MODE_START = 2'd0,
		MODE_DATA  = 2'd1,
		MODE_END   = 2'd2,
		MODE_ABORT = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD  = 2'd0,
		KIND_DATA_HDR = 2'd1,
		KIND_END_HDR  = 2'd2
	} kind_t;

	// Configuration register indexes.
	localparam logic CFG_SESSION_TAG = 1'b0;
	localparam logic CFG_NODE_ID     = 1'b1;

	// The per-result fields that differ between the two results of one request.
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic [31:0] offset;
		logic [10:0] plen;
	} res_t;

endpackage

// ===== sv/image_datagram_packetizer.sv =====
// ----------------------------------------------------------------------------
// Image datagram packetizer
// Cuts a compressed image byte stream into fixed-size datagram payloads and
// emits data headers after each chunk and an end header at frame close.
// ----------------------------------------------------------------------------
// A request accepted at an edge loads stage s1; its first result shows once it
// moves on into the result stage s2, behind the age multiply.
// Throughput: one request per cycle; a two-result request holds the result stage
// until both results are taken, the only input stall besides output back-pressure.
// Reset (arst_n low, asynchronous) clears all frame state and counters, empties
// the pipeline and sets the session tag to 1 and node_id to 0.
module image_datagram_packetizer
	import idp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	// Configuration write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,

	// Input request channel.
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [7:0]  byte_value,
	input  logic [15:0] image_width,
	input  logic [15:0] image_height,
	input  logic [47:0] capture_time_us,
	input  logic [47:0] now_us,

	// Result channel.
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  out_byte,
	output logic [31:0] frame_number,
	output logic [31:0] chunk_offset,
	output logic [31:0] total_size,
	output logic [10:0] payload_length,
	output logic [15:0] age_ms,
	output logic [15:0] dropped_frames,
	output logic [15:0] out_width,
	output logic [15:0] out_height,
	output logic        last
);

	// Configuration registers. They belong to the wire header and are held
	// here for the framing logic downstream; no result field carries them.
	logic [7:0] session_tag_q;
	logic [7:0] node_id_q;

	// Frame state.
	logic [10:0] fill_q;
	logic [31:0] offset_q;
	logic [31:0] frame_q;
	logic [15:0] drop_q;
	logic        open_q;
	logic [47:0] capture_q;
	logic [15:0] width_q;
	logic [15:0] height_q;

	// Next-state values and results of the request being accepted.
	logic [10:0] fill_d;
	logic [31:0] offset_d;
	logic [31:0] frame_d;
	logic [15:0] drop_d;
	logic        open_d;
	logic [1:0]  nres;
	res_t        r0;
	res_t        r1;

	logic [10:0] fill_inc;
	logic [31:0] offset_sum;
	logic [48:0] age_diff;

	// Stage 1: results of the accepted request plus the raw age difference.
	logic        valid_s1;
	logic        two_s1;
	res_t        r0_s1;
	res_t        r1_s1;
	logic [31:0] frame_s1;
	logic [15:0] drop_s1;
	logic [15:0] width_s1;
	logic [15:0] height_s1;
	logic [47:0] diff_s1;
	logic        neg_s1;

	// Stage 2: the result register, which may hold two results.
	logic        valid_s2;
	logic        two_s2;
	logic        ptr_s2;
	res_t        r0_s2;
	res_t        r1_s2;
	logic [31:0] frame_s2;
	logic [15:0] drop_s2;
	logic [15:0] width_s2;
	logic [15:0] height_s2;
	logic [15:0] age_s2;

	logic [52:0] age_prod;
	logic        accept;
	logic        out_take;
	logic        done_s2;
	logic        adv_s2;
	logic        adv_s1;
	res_t        cur;

	// The configuration port never pushes back.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			session_tag_q <= 8'd1;
			node_id_q     <= 8'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SESSION_TAG: session_tag_q <= cfg_data;
				CFG_NODE_ID:     node_id_q     <= cfg_data;
				default:         ;
			endcase
		end
	end

	// Handshake. The result register frees when its last result is taken;
	// stage 1 moves whenever stage 2 can take it, so a request is accepted
	// even while a finished result still waits at the output.
	assign out_take = valid_s2 && !out_stall;
	assign done_s2  = out_take && (ptr_s2 || !two_s2);
	assign adv_s2   = !valid_s2 || done_s2;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;
	assign accept   = in_valid && !in_stall;

	assign fill_inc   = fill_q + 11'd1;
	assign offset_sum = offset_q + {21'd0, fill_q};
	// Bit 48 is the borrow: the current time lies before the capture time.
	assign age_diff   = {1'b0, now_us} - {1'b0, capture_q};

	// Frame control: results of this request and the state it leaves.
	always_comb begin
		fill_d   = fill_q;
		offset_d = offset_q;
		frame_d  = frame_q;
		drop_d   = drop_q;
		open_d   = open_q;
		nres     = 2'd0;
		r0       = '{kind: KIND_PAYLOAD, data: 8'd0, offset: 32'd0, plen: 11'd0};
		r1       = r0;
		unique case (mode_t'(mode))
			MODE_START: begin
				// A start while a frame is open drops that frame.
				if (open_q) begin
					drop_d = drop_q + 16'd1;
				end
				frame_d  = frame_q + 32'd1;
				fill_d   = 11'd0;
				offset_d = 32'd0;
				open_d   = 1'b1;
			end
			MODE_DATA: begin
				if (open_q) begin
					nres    = 2'd1;
					r0.data = byte_value;
					fill_d  = fill_inc;
					// A full chunk is closed by a data header right after
					// its last byte.
					if (fill_inc >= CHUNK_SIZE[10:0]) begin
						nres      = 2'd2;
						r1.kind   = KIND_DATA_HDR;
						r1.offset = offset_q;
						r1.plen   = fill_inc;
						fill_d    = 11'd0;
						offset_d  = offset_q + {21'd0, fill_inc};
					end
				end
			end
			MODE_END: begin
				if (open_q) begin
					open_d = 1'b0;
					if (offset_q == 32'd0 && fill_q == 11'd0) begin
						// An empty frame counts as dropped and sends nothing.
						drop_d = drop_q + 16'd1;
					end else if (fill_q != 11'd0) begin
						// Flush the partial chunk, then the end header.
						nres      = 2'd2;
						r0.kind   = KIND_DATA_HDR;
						r0.offset = offset_q;
						r0.plen   = fill_q;
						r1.kind   = KIND_END_HDR;
						r1.offset = offset_sum;
						fill_d    = 11'd0;
						offset_d  = offset_sum;
					end else begin
						nres      = 2'd1;
						r0.kind   = KIND_END_HDR;
						r0.offset = offset_q;
					end
				end
			end
			MODE_ABORT: begin
				if (open_q) begin
					drop_d = drop_q + 16'd1;
					open_d = 1'b0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			offset_q  <= '0;
			frame_q   <= '0;
			drop_q    <= '0;
			open_q    <= 1'b0;
			capture_q <= '0;
			width_q   <= '0;
			height_q  <= '0;
		end else if (accept) begin
			fill_q   <= fill_d;
			offset_q <= offset_d;
			frame_q  <= frame_d;
			drop_q   <= drop_d;
			open_q   <= open_d;
			if (mode_t'(mode) == MODE_START) begin
				capture_q <= capture_time_us;
				width_q   <= image_width;
				height_q  <= image_height;
			end
		end
	end

	// Stage 1 register. Requests without results leave no bubble behind.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= accept && (nres != 2'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			two_s1    <= (nres == 2'd2);
			r0_s1     <= r0;
			r1_s1     <= r1;
			frame_s1  <= frame_q;
			drop_s1   <= drop_q;
			width_s1  <= width_q;
			height_s1 <= height_q;
			diff_s1   <= age_diff[47:0];
			neg_s1    <= age_diff[48];
		end
	end

	// Milliseconds by reciprocal multiply; only differences below the
	// saturation point need the quotient, and those fit in 26 bits.
	assign age_prod = 53'(diff_s1[25:0]) * 53'(AGE_RECIP);

	// Stage 2: result register with a pointer to the result on show.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			ptr_s2   <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
			ptr_s2   <= 1'b0;
		end else if (out_take) begin
			ptr_s2 <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			two_s2    <= two_s1;
			r0_s2     <= r0_s1;
			r1_s2     <= r1_s1;
			frame_s2  <= frame_s1;
			drop_s2   <= drop_s1;
			width_s2  <= width_s1;
			height_s2 <= height_s1;
			if (neg_s1) begin
				age_s2 <= 16'd0;
			end else if (diff_s1 >= AGE_SAT_US) begin
				age_s2 <= 16'hFFFF;
			end else begin
				age_s2 <= age_prod[AGE_SHIFT+15:AGE_SHIFT];
			end
		end
	end

	// Output selection.
	assign cur            = ptr_s2 ? r1_s2 : r0_s2;
	assign out_valid      = valid_s2;
	assign kind           = cur.kind;
	assign out_byte       = cur.data;
	assign frame_number   = frame_s2;
	assign chunk_offset   = cur.offset;
	assign total_size     = (cur.kind == KIND_END_HDR) ? cur.offset : 32'd0;
	assign payload_length = cur.plen;
	assign age_ms         = (cur.kind == KIND_PAYLOAD) ? 16'd0 : age_s2;
	assign dropped_frames = drop_s2;
	assign out_width      = width_s2;
	assign out_height     = height_s2;
	assign last           = ptr_s2 || !two_s2;

	// The second result is only ever shown for a two-result request.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && ptr_s2) |-> two_s2)
		else $error("second result shown for a single-result request");

	// A chunk is closed as soon as it fills, so the fill never reaches it.
	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < CHUNK_SIZE[10:0])
		else $error("fill count reached the chunk size");

	// The end header always closes the results of its request.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && cur.kind == KIND_END_HDR) |-> last)
		else $error("end header not marked last");

	// With the pipeline empty, no request is ever held off.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!valid_s1 && !valid_s2) |-> !in_stall)
		else $error("input stalled with an empty pipeline");

	// A configuration write lands in the addressed register.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |=>
		(($past(cfg_index) == CFG_SESSION_TAG && session_tag_q == $past(cfg_data)) ||
		 ($past(cfg_index) == CFG_NODE_ID && node_id_q == $past(cfg_data))))
		else $error("configuration write lost");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image datagram packetizer testbench
// Drives start, data, end and abort requests into the packetizer, predicts
// every payload byte, data header and end header from a behavioral copy of
// the frame state, and compares each result field by field. Both channels
// idle in random bursts; one phase holds the result side off long enough
// that the block has to stall its input.
// ----------------------------------------------------------------------------
module tb_top;
	import idp_pkg::*;

	// A quiet run of this many edges, with no request, result or register
	// write accepted, means the block has hung.
	localparam int QUIET_LIMIT = 2000;

	// Pause after the last expected result before touching the registers or
	// ending the run. Requests that make no result may still be in flight.
	localparam int DRAIN_EDGES = 8;

	// One result as it should appear on the output pins.
	typedef struct {
		kind_t       kind;
		logic [7:0]  data;
		logic [31:0] frame;
		logic [31:0] offset;
		logic [31:0] total;
		logic [10:0] plen;
		logic [15:0] age;
		logic [15:0] drops;
		logic [15:0] width;
		logic [15:0] height;
		logic        last;
	} datagram_t;

	logic        clk;
	logic        arst_n;

	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [7:0]  cfg_data;

	logic        in_valid;
	logic        in_stall;
	logic [1:0]  mode;
	logic [7:0]  byte_value;
	logic [15:0] image_width;
	logic [15:0] image_height;
	logic [47:0] capture_time_us;
	logic [47:0] now_us;

	logic        out_valid;
	logic        out_stall;
	logic [1:0]  kind;
	logic [7:0]  out_byte;
	logic [31:0] frame_number;
	logic [31:0] chunk_offset;
	logic [31:0] total_size;
	logic [10:0] payload_length;
	logic [15:0] age_ms;
	logic [15:0] dropped_frames;
	logic [15:0] out_width;
	logic [15:0] out_height;
	logic        last;

	image_datagram_packetizer u_top (
		.clk, .arst_n,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.in_valid, .in_stall, .mode, .byte_value, .image_width, .image_height,
		.capture_time_us, .now_us,
		.out_valid, .out_stall, .kind, .out_byte, .frame_number, .chunk_offset,
		.total_size, .payload_length, .age_ms, .dropped_frames, .out_width,
		.out_height, .last
	);

	// Results still owed by the block, oldest first.
	datagram_t expected_datagrams[$];

	// Shadow of the packetizer's frame state, advanced on every accepted
	// request. The configuration registers need no shadow: the tag and node
	// identity never reach a result field.
	logic [10:0] p_fill;
	logic [31:0] p_offset;
	logic [31:0] p_frame;
	logic [15:0] p_drops;
	logic        p_open;
	logic [47:0] p_capture;
	logic [15:0] p_width;
	logic [15:0] p_height;

	int          errors = 0;
	int          quiet_edges = 0;
	bit          idling_on = 1'b1;
	int          long_hold_request = 0;
	logic [47:0] frame_capture = '0;

	// ------------------------------------------------------------------------
	// Clock and watchdog
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// The watchdog only looks at quiet edges after reset, so a slow but
	// moving run never trips it, however long it is.
	initial begin
		while (quiet_edges < QUIET_LIMIT) @(posedge clk);
		$display("CHECKS FAILED");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Frame state prediction
	// ------------------------------------------------------------------------

	// Header age: whole milliseconds since capture. A timestamp earlier than
	// the capture gives zero, and anything past 65535 ms saturates.
	function automatic logic [15:0] age_in_ms(logic [47:0] now);
		logic [47:0] diff_ms;
		if (now < p_capture) return 16'd0;
		diff_ms = (now - p_capture) / 48'd1000;
		return (diff_ms > 48'd65535) ? 16'hFFFF : diff_ms[15:0];
	endfunction

	// Every result carries the frame number, the drop count and the latched
	// image size as they stand at the moment it is made.
	function automatic datagram_t make_datagram(kind_t k, logic [7:0] b, logic [31:0] offset,
			logic [31:0] total, logic [10:0] plen, logic [15:0] age);
		datagram_t d;
		d.kind   = k;
		d.data   = b;
		d.frame  = p_frame;
		d.offset = offset;
		d.total  = total;
		d.plen   = plen;
		d.age    = age;
		d.drops  = p_drops;
		d.width  = p_width;
		d.height = p_height;
		d.last   = 1'b0;
		return d;
	endfunction

	// A data header describes the chunk just finished, then the offset moves
	// past it and the fill starts over.
	function automatic datagram_t close_chunk(logic [47:0] now);
		datagram_t d;
		d = make_datagram(KIND_DATA_HDR, 8'd0, p_offset, 32'd0, p_fill, age_in_ms(now));
		p_offset = p_offset + {21'd0, p_fill};
		p_fill = '0;
		return d;
	endfunction

	function automatic void drop_open_frame();
		p_drops = p_drops + 16'd1;
		p_open = 1'b0;
	endfunction

	function automatic void predict_datagrams(mode_t m, logic [7:0] b, logic [15:0] w,
			logic [15:0] h, logic [47:0] cap, logic [47:0] now);
		datagram_t batch[2];
		int n;
		n = 0;
		if (m == MODE_START) begin
			// A start on top of an open frame throws that frame away first.
			if (p_open) drop_open_frame();
			p_frame = p_frame + 32'd1;
			p_fill = '0;
			p_offset = '0;
			p_capture = cap;
			p_width = w;
			p_height = h;
			p_open = 1'b1;
		end else if (p_open) begin
			case (m)
				MODE_DATA: begin
					batch[n] = make_datagram(KIND_PAYLOAD, b, '0, '0, '0, '0);
					n++;
					p_fill = p_fill + 11'd1;
					if (p_fill >= CHUNK_SIZE) begin
						batch[n] = close_chunk(now);
						n++;
					end
				end
				MODE_END: begin
					// A frame that never got a byte counts as dropped and says
					// nothing on the output.
					if (p_offset == 0 && p_fill == 0) begin
						drop_open_frame();
					end else begin
						if (p_fill != 0) begin
							batch[n] = close_chunk(now);
							n++;
						end
						batch[n] = make_datagram(KIND_END_HDR, 8'd0, p_offset, p_offset,
							'0, age_in_ms(now));
						n++;
						p_open = 1'b0;
					end
				end
				default: begin
					drop_open_frame();
				end
			endcase
		end
		// With no frame open, data, end and abort requests leave no trace.
		if (n > 0) batch[n - 1].last = 1'b1;
		for (int i = 0; i < n; i++) expected_datagrams.push_back(batch[i]);
	endfunction

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	// ------------------------------------------------------------------------
	// Result checker
	// Everything is sampled at the rising edge. Accepted requests are
	// predicted before results are popped, so a request and a result on the
	// same edge are always handled in that order.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		datagram_t want;
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				moved = 1'b1;
			end
			if (in_valid && !in_stall) begin
				moved = 1'b1;
				predict_datagrams(mode_t'(mode), byte_value, image_width, image_height,
					capture_time_us, now_us);
			end
			if (out_valid && !out_stall) begin
				moved = 1'b1;
				if (expected_datagrams.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, actual kind %0d",
						$time, kind);
				end else begin
					want = expected_datagrams.pop_front();
					check_field("kind", 64'(want.kind), 64'(kind));
					check_field("out_byte", 64'(want.data), 64'(out_byte));
					check_field("frame_number", 64'(want.frame), 64'(frame_number));
					check_field("chunk_offset", 64'(want.offset), 64'(chunk_offset));
					check_field("total_size", 64'(want.total), 64'(total_size));
					check_field("payload_length", 64'(want.plen), 64'(payload_length));
					check_field("age_ms", 64'(want.age), 64'(age_ms));
					check_field("dropped_frames", 64'(want.drops), 64'(dropped_frames));
					check_field("out_width", 64'(want.width), 64'(out_width));
					check_field("out_height", 64'(want.height), 64'(out_height));
					check_field("last", 64'(want.last), 64'(last));
				end
			end
			quiet_edges = moved ? 0 : quiet_edges + 1;
		end
	end

	// ------------------------------------------------------------------------
	// Result side flow control
	// Random stall bursts of random length while idling is on. A long
	// hold-off can be asked for; it is counted here, independent of the
	// request side, so the request side can keep pushing into a full block.
	// ------------------------------------------------------------------------
	initial begin
		int burst;
		int hold;
		burst = 0;
		hold = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_request > 0) begin
				hold = long_hold_request;
				long_hold_request = 0;
			end
			if (hold > 0) begin
				hold--;
				out_stall <= 1'b1;
			end else if (burst > 0) begin
				burst--;
				out_stall <= 1'b1;
			end else if (idling_on && $urandom_range(0, 7) == 0) begin
				burst = $urandom_range(1, 15) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------------

	// Inputs change at the falling edge only. A request stays up, unchanged,
	// until the block takes it; the next call either replaces it directly or
	// drops valid for a random gap first.
	task automatic send_item(mode_t m, logic [7:0] b, logic [15:0] w, logic [15:0] h,
			logic [47:0] cap, logic [47:0] now);
		int gap;
		gap = (idling_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 15) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid        <= 1'b1;
		mode            <= m;
		byte_value      <= b;
		image_width     <= w;
		image_height    <= h;
		capture_time_us <= cap;
		now_us          <= now;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic stop_sending();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// Waits until every owed result is out, then lets a request that makes
	// no result clear the pipeline as well.
	task automatic wait_quiet();
		stop_sending();
		while (expected_datagrams.size() != 0) @(posedge clk);
		repeat (DRAIN_EDGES) @(posedge clk);
	endtask

	task automatic write_register(logic index, logic [7:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Registers are only ever written with the block idle.
	task automatic program_ids(logic [7:0] tag, logic [7:0] node);
		wait_quiet();
		write_register(CFG_SESSION_TAG, tag);
		write_register(CFG_NODE_ID, node);
	endtask

	function automatic logic [47:0] random_stamp();
		return 48'({$urandom, $urandom});
	endfunction

	// Current time relative to the frame's capture: mostly a plausible age,
	// with ages around the saturation point, clocks running backwards and
	// completely unrelated values mixed in.
	function automatic logic [47:0] random_now(logic [47:0] cap);
		case ($urandom_range(0, 9))
			0: return random_stamp();
			1: return cap - 48'($urandom_range(1, 5000));
			2: return cap + 48'd65535000 + 48'($urandom_range(0, 1999));
			3: return cap + 48'd65536000 + 48'($urandom_range(0, 100000));
			default: return cap + 48'($urandom_range(0, 66000000));
		endcase
	endfunction

	// Fields that a request does not use still get random values, so every
	// input bit moves regardless of mode.
	task automatic send_start(logic [47:0] cap);
		frame_capture = cap;
		send_item(MODE_START, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
			16'($urandom_range(0, 65535)), cap, random_now(cap));
	endtask

	task automatic send_request(mode_t m);
		send_item(m, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
			16'($urandom_range(0, 65535)), random_stamp(), random_now(frame_capture));
	endtask

	// One random frame, or a stray request with no frame open. Frame lengths
	// are mostly short so that the boundaries come often.
	task automatic random_frame(inout int sent);
		int pick;
		int len;
		pick = $urandom_range(0, 99);
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 250) : $urandom_range(1, 40);
		if (pick < 8) begin
			// Stray data, end or abort on a closed frame; ignored by the block.
			send_request(mode_t'($urandom_range(1, 3)));
		end else begin
			send_start(random_stamp());
			sent++;
			if (pick >= 80 && pick < 88) len = 0;
			if (pick >= 88 && pick < 94) begin
				// Restart on top of a frame that has bytes in it.
				repeat ($urandom_range(1, 5)) send_request(MODE_DATA);
				send_start(random_stamp());
				sent++;
			end
			repeat (len) send_request(MODE_DATA);
			sent += len;
			send_request((pick >= 70 && pick < 80) || pick >= 94 ? MODE_ABORT : MODE_END);
			sent++;
		end
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Field extremes, every mode, and the special cases: requests with no
	// frame open, empty frame, abort, restart on an open frame, ages below
	// zero, at one millisecond, at the last unsaturated value and saturated.
	task automatic test_directed();
		program_ids(8'd255, 8'd0);
		send_item(MODE_DATA, 8'h5A, 16'd0, 16'd0, '0, '0);
		send_item(MODE_END, 8'h00, 16'd0, 16'd0, '0, '0);
		send_item(MODE_ABORT, 8'h00, 16'd0, 16'd0, '0, '0);

		send_item(MODE_START, 8'h00, 16'd0, 16'd0, 48'd0, 48'd0);
		send_item(MODE_DATA, 8'h00, 16'd0, 16'd0, '0, 48'd0);
		send_item(MODE_DATA, 8'hFF, 16'd0, 16'd0, '0, 48'd0);
		send_item(MODE_END, 8'h00, 16'd0, 16'd0, '0, 48'd999);

		send_item(MODE_START, 8'hFF, 16'hFFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF,
			48'hFFFF_FFFF_FFFF);
		send_item(MODE_DATA, 8'hA5, 16'hFFFF, 16'hFFFF, '1, '1);
		send_item(MODE_END, 8'h00, 16'hFFFF, 16'hFFFF, '1, 48'd0);

		send_item(MODE_START, 8'h00, 16'h1234, 16'h0001, 48'd0, 48'd0);
		send_item(MODE_DATA, 8'h81, 16'd0, 16'd0, '0, 48'd0);
		send_item(MODE_END, 8'h00, 16'd0, 16'd0, '0, 48'd65535999);

		send_item(MODE_START, 8'h00, 16'h0001, 16'h8000, 48'd1000, 48'd0);
		send_item(MODE_DATA, 8'h7E, 16'd0, 16'd0, '0, 48'd0);
		send_item(MODE_END, 8'h00, 16'd0, 16'd0, '0, 48'hFFFF_FFFF_FFFF);

		send_item(MODE_START, 8'h00, 16'd320, 16'd240, 48'd50, 48'd50);
		send_item(MODE_END, 8'h00, 16'd0, 16'd0, '0, 48'd60);

		send_item(MODE_START, 8'h00, 16'd640, 16'd480, 48'd50, 48'd50);
		send_item(MODE_DATA, 8'h33, 16'd0, 16'd0, '0, 48'd70);
		send_item(MODE_ABORT, 8'h00, 16'd0, 16'd0, '0, 48'd80);

		send_item(MODE_START, 8'h00, 16'd800, 16'd600, 48'd3, 48'd3);
		send_item(MODE_DATA, 8'h01, 16'd0, 16'd0, '0, 48'd4);
		send_item(MODE_START, 8'h00, 16'd1024, 16'd768, 48'd7, 48'd7);
		send_item(MODE_DATA, 8'h80, 16'd0, 16'd0, '0, 48'd8);
		send_item(MODE_END, 8'h00, 16'd0, 16'd0, '0, 48'd1007);
	endtask

	// A frame of exactly one chunk gets its data header right after the last
	// byte, and then the end header alone.
	task automatic test_full_chunks();
		program_ids(8'd1, 8'd255);
		send_start(random_stamp());
		repeat (CHUNK_SIZE) send_request(MODE_DATA);
		send_request(MODE_END);
	endtask

	// The result side stops for a long stretch while bytes keep coming, so
	// the pipeline fills and the block has to stall its input.
	task automatic test_output_hold_off();
		program_ids(8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)));
		send_start(random_stamp());
		long_hold_request = 300;
		repeat (20) send_request(MODE_DATA);
		send_request(MODE_END);
	endtask

	// Random frames in three stretches: idling, none, idling again, with the
	// registers rewritten between them.
	task automatic test_random_traffic(int target);
		int sent;
		sent = 0;
		program_ids(8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)));
		idling_on = 1'b1;
		while (sent < target * 2 / 5) random_frame(sent);
		program_ids(8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)));
		idling_on = 1'b0;
		while (sent < target * 3 / 5) random_frame(sent);
		program_ids(8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)));
		idling_on = 1'b1;
		while (sent < target) random_frame(sent);
	endtask

	// Closing stretch at full rate on both sides.
	task automatic test_steady_stream();
		int sent;
		sent = 0;
		program_ids(8'd255, 8'd255);
		idling_on = 1'b0;
		while (sent < 40) random_frame(sent);
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n          = 1'b0;
		cfg_valid       = 1'b0;
		cfg_index       = CFG_SESSION_TAG;
		cfg_data        = 8'd0;
		in_valid        = 1'b0;
		mode            = MODE_START;
		byte_value      = 8'd0;
		image_width     = 16'd0;
		image_height    = 16'd0;
		capture_time_us = 48'd0;
		now_us          = 48'd0;

		// Shadow state starts from the reset values.
		p_fill    = '0;
		p_offset  = '0;
		p_frame   = '0;
		p_drops   = '0;
		p_open    = 1'b0;
		p_capture = '0;
		p_width   = '0;
		p_height  = '0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_full_chunks();
		test_output_hold_off();
		test_random_traffic(120);
		test_steady_stream();

		// Anything left in flight either arrives here or trips the watchdog.
		wait_quiet();
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
